// ----- sv/atab_pkg.sv -----
// Shared types and constants for the alarm table block.
// No dependencies; used by alarm_table_earliest_deadline.
`default_nettype none
package atab_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ID_WIDTH    = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] MAX_WAIT      = 32'd2147000;
    localparam logic [31:0] DATA_WILDCARD = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [31:0]         tim;
        logic [ID_WIDTH-1:0] chan;
        logic [ID_WIDTH-1:0] msg;
        logic [31:0]         data;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

// ----- sv/atab_mem.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; no package dependency.
`default_nettype none
module atab_mem #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/alarm_table_earliest_deadline.sv -----
// Alarm table with earliest-deadline tick: control, scan and report logic.
// Depends on atab_pkg and atab_mem.
//
// Usage: commands enter on the input channel (i_valid / o_stall) and each
// produces exactly one result on the output channel (o_valid / i_stall).
// A transaction is taken when valid is high and stall is low.
// Add checks the whole table for an exact duplicate, then appends. Delete
// and a due tick stream every entry through the RAM once, writing kept
// entries back towards the front to close gaps and tracking the new minimum.
// Each command runs through the scan, update and report states before its
// result reaches the output register; the scan reads one entry per cycle
// from the RAM read port over the entries held (up to 32). A tick that is
// not due and the unused code skip the scan. The next command can be taken
// in the cycle after the result is loaded.
// Only one command is in flight; o_stall stays high until its result has
// been loaded into the output register, which may still hold an earlier
// result while the next command is scanned. If the receiver stalls, the
// result is held and the block waits before loading the next one.
// Reset empties the table; RAM contents are not cleared (entries beyond the
// count are never read).
`default_nettype none
module alarm_table_earliest_deadline (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_now_seconds,
    input  wire logic [31:0] i_alarm_seconds,
    input  wire logic [15:0] i_channel_id,
    input  wire logic [15:0] i_message_id,
    input  wire logic signed [31:0] i_alarm_data,
    input  wire logic        i_time_any,
    input  wire logic        i_channel_any,
    input  wire logic        i_message_any,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_fired,
    output logic [31:0]      o_fired_time,
    output logic [15:0]      o_fired_channel,
    output logic [15:0]      o_fired_message,
    output logic signed [31:0] o_fired_data,
    output logic [31:0]      o_wake_time,
    output logic [21:0]      o_wait_seconds,
    output logic             o_table_full,
    output logic             o_duplicate,
    output logic [5:0]       o_removed_count
);

    localparam int IDX_W = atab_pkg::IDX_W;
    localparam int CNT_W = atab_pkg::CNT_W;

    atab_pkg::t_state r_state, n_state;
    atab_pkg::t_cmd   r_cmd;
    atab_pkg::t_entry r_key, r_fent, rd_data, wr_data;

    logic [31:0]      r_now;
    logic             r_t_any, r_c_any, r_m_any, r_due;
    logic [CNT_W-1:0] r_count, r_rd, r_wp, r_removed;
    logic [IDX_W-1:0] r_early, r_didx, r_me;
    logic [31:0]      r_min_time, r_mt;
    logic             r_dv, r_mv, r_dup, r_full, r_fired;

    logic             accept, out_free, do_pass, compact, hit, exact, keep, add_ok;
    logic             rd_en, wr_en, scan_done;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wake, diff;

    assign accept   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;
    assign do_pass  = (r_cmd == atab_pkg::CMD_ADD) || (r_cmd == atab_pkg::CMD_DEL)
                      || ((r_cmd == atab_pkg::CMD_TICK) && r_due);
    assign compact  = (r_cmd == atab_pkg::CMD_DEL)
                      || ((r_cmd == atab_pkg::CMD_TICK) && r_due);
    assign scan_done = !do_pass || (!r_dv && (r_rd >= r_count));
    assign add_ok   = (r_cmd == atab_pkg::CMD_ADD) && !r_dup
                      && (r_count < CNT_W'(atab_pkg::TABLE_DEPTH));

    assign exact = (rd_data == r_key);

    always_comb begin
        if (r_cmd == atab_pkg::CMD_DEL) begin
            hit = (r_t_any || rd_data.tim == r_key.tim)
               && (r_c_any || rd_data.chan == r_key.chan)
               && (r_m_any || rd_data.msg == r_key.msg)
               && (r_key.data == atab_pkg::DATA_WILDCARD || rd_data.data == r_key.data);
        end else begin
            hit = (r_didx == r_early);
        end
    end

    assign keep = r_dv && compact && !hit;

    atab_mem #(
        .WIDTH (atab_pkg::ENTRY_W),
        .DEPTH (atab_pkg::TABLE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd[IDX_W-1:0]),
        .o_rd_data(rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            atab_pkg::ST_IDLE:   if (accept) n_state = atab_pkg::ST_SCAN;
            atab_pkg::ST_SCAN:   if (scan_done) n_state = atab_pkg::ST_UPDATE;
            atab_pkg::ST_UPDATE: n_state = atab_pkg::ST_REPORT;
            atab_pkg::ST_REPORT: if (out_free) n_state = atab_pkg::ST_IDLE;
            default:             n_state = atab_pkg::ST_IDLE;
        endcase
    end

    // RAM control and handshake
    always_comb begin
        o_stall = (r_state != atab_pkg::ST_IDLE);
        rd_en   = (r_state == atab_pkg::ST_SCAN) && do_pass && (r_rd < r_count);
        wr_en   = 1'b0;
        wr_addr = r_wp[IDX_W-1:0];
        wr_data = rd_data;
        unique case (r_state)
            atab_pkg::ST_SCAN: wr_en = keep;
            atab_pkg::ST_UPDATE: begin
                wr_en   = add_ok;
                wr_addr = r_count[IDX_W-1:0];
                wr_data = r_key;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atab_pkg::ST_IDLE;
            r_count <= '0;
            r_early <= '0;
            r_dv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall && (r_state != atab_pkg::ST_REPORT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                atab_pkg::ST_IDLE: begin
                    r_dv <= 1'b0;
                    if (accept) begin
                        r_cmd      <= atab_pkg::t_cmd'(i_cmd);
                        r_now      <= i_now_seconds;
                        r_key.tim  <= i_alarm_seconds;
                        r_key.chan <= i_channel_id[atab_pkg::ID_WIDTH-1:0];
                        r_key.msg  <= i_message_id[atab_pkg::ID_WIDTH-1:0];
                        r_key.data <= i_alarm_data;
                        r_t_any    <= i_time_any;
                        r_c_any    <= i_channel_any;
                        r_m_any    <= i_message_any;
                        r_due      <= (r_count != '0) && (r_min_time <= i_now_seconds);
                        r_rd       <= '0;
                        r_wp       <= '0;
                        r_removed  <= '0;
                        r_mv       <= 1'b0;
                        r_dup      <= 1'b0;
                        r_full     <= 1'b0;
                        r_fired    <= 1'b0;
                        r_fent     <= '0;
                    end
                end
                atab_pkg::ST_SCAN: begin
                    r_dv   <= rd_en;
                    r_didx <= r_rd[IDX_W-1:0];
                    if (rd_en) begin
                        r_rd <= r_rd + CNT_W'(1);
                    end
                    if (r_dv) begin
                        if (!compact) begin
                            if (exact) r_dup <= 1'b1;
                        end else if (hit) begin
                            if (r_cmd == atab_pkg::CMD_TICK) begin
                                r_fired <= 1'b1;
                                r_fent  <= rd_data;
                            end else begin
                                r_removed <= r_removed + CNT_W'(1);
                            end
                        end else begin
                            // keep: track first minimum at its new position
                            r_wp <= r_wp + CNT_W'(1);
                            if (!r_mv || rd_data.tim < r_mt) begin
                                r_mv <= 1'b1;
                                r_mt <= rd_data.tim;
                                r_me <= r_wp[IDX_W-1:0];
                            end
                        end
                    end
                end
                atab_pkg::ST_UPDATE: begin
                    if (compact) begin
                        r_count    <= r_wp;
                        r_early    <= r_mv ? r_me : '0;
                        r_min_time <= r_mt;
                    end else if (r_cmd == atab_pkg::CMD_ADD && !r_dup) begin
                        if (add_ok) begin
                            r_count <= r_count + CNT_W'(1);
                            if (r_count == '0 || r_key.tim < r_min_time) begin
                                r_min_time <= r_key.tim;
                                r_early    <= r_count[IDX_W-1:0];
                            end
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                end
                atab_pkg::ST_REPORT: begin
                    if (out_free) begin
                        o_valid         <= 1'b1;
                        o_fired         <= r_fired;
                        o_fired_time    <= r_fent.tim;
                        o_fired_channel <= 16'(r_fent.chan);
                        o_fired_message <= 16'(r_fent.msg);
                        o_fired_data    <= r_fent.data;
                        o_wake_time     <= wake;
                        o_wait_seconds  <= (diff > atab_pkg::MAX_WAIT)
                                           ? atab_pkg::MAX_WAIT[21:0] : diff[21:0];
                        o_table_full    <= r_full;
                        o_duplicate     <= r_dup;
                        o_removed_count <= 6'(r_removed);
                    end
                end
                default: r_dv <= 1'b0;
            endcase
        end
    end

    always_comb begin
        if (r_count == '0) begin
            wake = '0;
        end else if (r_min_time < r_now) begin
            wake = r_now;
        end else begin
            wake = r_min_time;
        end
        diff = (r_count == '0) ? '0 : (wake - r_now);
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(atab_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atab_pkg::ST_SCAN && r_dv) |-> (r_wp <= CNT_W'(r_didx)))
        else $error("compaction write pointer overtook read pointer");

    a_single_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction accepted while busy");

    a_no_stale_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atab_pkg::ST_UPDATE) |-> !r_dv)
        else $error("scan left unprocessed RAM data");

endmodule
`default_nettype wire
